// ----- rtl/core/bpa_pkg.sv -----
// Package for the buddy page allocator: shared constants, codes and state types.
// Used by the channel interfaces, the top level and the testbench.
`default_nettype none

package bpa_pkg;

    // Default geometry of the page table.
    localparam int NUM_PAGES_DEF = 1024;
    localparam int ORDER_CAP_DEF = 10;

    // Fixed field widths of the request and response beats.
    localparam int CMD_W      = 2;
    localparam int BYTES_W    = 32;
    localparam int PAGE_F_W   = 10;
    localparam int ORDER_F_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int FIRST_W    = 10;
    localparam int POOLSZ_W   = 11;
    localparam int KIND_W     = 2;

    // Byte count to page count rounding.
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_ROUND = 4095;
    localparam int PGCNT_W    = BYTES_W + 1 - PAGE_SHIFT;

    // Configuration register map.
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int POOLSZ_RST = 1024;

    typedef enum logic [0:0] {
        REG_FIRST_PAGE = 1'b0,
        REG_POOL_PAGES = 1'b1
    } t_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BADFREE = 2'd2
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        K_NONE = 2'd0,
        K_FREE = 2'd1,
        K_USED = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CARVE,
        S_AREQ,
        S_SCAN,
        S_SCAN_LAST,
        S_SPLIT,
        S_FREAD,
        S_FCHK,
        S_BUD,
        S_BCHK,
        S_MLOW,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/core/bpa_channels.sv -----
// Valid/ready channel interfaces for the allocator request and response beats.
// Depends on bpa_pkg for the field widths.
`default_nettype none

interface bpa_req_if
    import bpa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [BYTES_W-1:0]  request_bytes;
    logic [PAGE_F_W-1:0] page_number;

    modport source (output valid, command, request_bytes, page_number, input ready);
    modport sink   (input valid, command, request_bytes, page_number, output ready);
endinterface

interface bpa_rsp_if
    import bpa_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PAGE_F_W-1:0]  block_page;
    logic [ORDER_F_W-1:0] block_log2;

    modport source (output valid, status, block_page, block_log2, input ready);
    modport sink   (input valid, status, block_page, block_log2, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bpa_table.sv -----
// Page table memory: one write port and one registered read port.
// Stands alone; the top level packs kind and order into each entry.
`default_nettype none

module bpa_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/buddy_page_allocator_top.sv -----
// Buddy page allocator top level: APB register port, command sequencer, page table.
// Depends on bpa_pkg, bpa_channels and bpa_table.
`default_nettype none

// The block takes one command beat at a time and answers each with exactly one
// response beat. Table steps use the one write port and the one read port of the
// page table, one entry per cycle. After reset a clearing pass over the whole table
// runs before the first command is taken. Init clears every entry and then carves
// the pool from the largest order down to order zero. Allocate decodes the request,
// scans the full table and then splits the best block once per order down to the
// request. Free reads and checks the page, then per merge reads and checks the buddy
// and writes the merged head; the walk ends when the buddy cannot be merged. Every
// command then loads the response register, waiting while the previous response is
// still held. Configuration writes take effect at the next init.
module buddy_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int ORDER_CAP = ORDER_CAP_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    bpa_req_if.sink                i_req,
    bpa_rsp_if.source              o_rsp
);

    localparam int PW     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int ORD_W  = $clog2(ORDER_CAP + 2);
    localparam int DW     = KIND_W + ORD_W;
    localparam int CW0    = (PW > PAGE_F_W) ? PW : PAGE_F_W;
    localparam int CW1    = (CW0 > ORDER_CAP + 1) ? CW0 : ORDER_CAP + 1;
    localparam int CW     = CW1 + 2;

    localparam logic [CW-1:0]    NUM_C   = CW'(NUM_PAGES);
    localparam logic [PW-1:0]    LAST_IX = PW'(NUM_PAGES - 1);
    localparam logic [ORD_W-1:0] MAX_O   = ORD_W'(ORDER_CAP);
    localparam logic [ORD_W-1:0] NO_O    = ORD_W'(ORDER_CAP + 1);

    // Configuration registers.
    logic [FIRST_W-1:0]  r_cfg_first;
    logic [POOLSZ_W-1:0] r_cfg_pages;
    t_reg                cfg_sel;

    assign cfg_sel = t_reg'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_first <= '0;
            r_cfg_pages <= POOLSZ_W'(POOLSZ_RST);
        end else if (psel && penable && pwrite) begin
            unique case (cfg_sel)
                REG_FIRST_PAGE: r_cfg_first <= pwdata[FIRST_W-1:0];
                REG_POOL_PAGES: r_cfg_pages <= pwdata[POOLSZ_W-1:0];
                default:        r_cfg_first <= r_cfg_first;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_FIRST_PAGE: prdata = APB_DW'(r_cfg_first);
            REG_POOL_PAGES: prdata = APB_DW'(r_cfg_pages);
            default:        prdata = '0;
        endcase
    end

    // Sequencer and datapath registers.
    t_state              r_state, n_state;
    logic                r_clr_init, n_clr_init;
    logic [PW-1:0]       r_idx, n_idx;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;
    logic [CW-1:0]       r_pg, n_pg;
    logic [FIRST_W-1:0]  r_base, n_base;
    logic [POOLSZ_W-1:0] r_pages, n_pages;
    logic [CW-1:0]       r_off, n_off;
    logic [ORD_W-1:0]    r_ord, n_ord;
    logic [ORD_W-1:0]    r_req, n_req;
    logic [CW-1:0]       r_best, n_best;
    logic [ORD_W-1:0]    r_best_ord, n_best_ord;
    logic [CW-1:0]       r_bud, n_bud;
    logic                r_pend, n_pend;
    logic [PW-1:0]       r_pend_pg, n_pend_pg;
    t_status             r_res_st, n_res_st;
    logic [CW-1:0]       r_res_pg, n_res_pg;
    logic [ORD_W-1:0]    r_res_ord, n_res_ord;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_st, n_out_st;
    logic [PAGE_F_W-1:0] r_out_pg, n_out_pg;
    logic [ORDER_F_W-1:0] r_out_ord, n_out_ord;

    // Page table port.
    logic          tbl_we;
    logic [PW-1:0] tbl_waddr;
    logic [DW-1:0] tbl_wdata;
    logic [PW-1:0] tbl_raddr;
    logic [DW-1:0] tbl_rdata;
    t_kind         rd_kind;
    logic [ORD_W-1:0] rd_ord;

    bpa_table #(
        .DEPTH (NUM_PAGES),
        .AW    (PW),
        .DW    (DW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign rd_kind = t_kind'(tbl_rdata[DW-1 -: KIND_W]);
    assign rd_ord  = tbl_rdata[ORD_W-1:0];

    // Shared conditions of the sequencer.
    logic               in_fire;
    logic               resp_load;
    logic [CW-1:0]      carve_size, carve_start;
    logic [CW-1:0]      pages_ext;
    logic               carve_bit, carve_fits;
    logic [PGCNT_W:0]   pg_cnt;
    logic [ORD_W-1:0]   areq_ord;
    logic               areq_found;
    logic               scan_hit;
    logic [ORD_W-1:0]   split_ord;
    logic [CW-1:0]      split_bud;
    logic               pg_oob;
    logic [CW-1:0]      off_diff, bud_size, bud_calc;
    logic               bud_bad;
    logic               merge_ok;
    logic [CW-1:0]      m_low, m_high;

    assign in_fire   = i_req.valid && i_req.ready;
    assign resp_load = !r_out_valid || o_rsp.ready;

    assign carve_size  = CW'(1) << r_ord;
    assign carve_start = CW'(r_base) + r_off;
    assign pages_ext   = CW'(r_pages);
    assign carve_bit   = pages_ext[r_ord];
    assign carve_fits  = (carve_start + carve_size) <= NUM_C;

    // Smallest order whose size covers the rounded page count.
    always_comb begin
        int r;
        pg_cnt     = (PGCNT_W + 1)'((33'(r_bytes) + 33'(PAGE_ROUND)) >> PAGE_SHIFT);
        areq_ord   = '0;
        areq_found = 1'b0;
        for (r = 0; r <= ORDER_CAP; r++) begin
            if (!areq_found && (((PGCNT_W + 1)'(1) << r) >= pg_cnt)) begin
                areq_found = 1'b1;
                areq_ord   = ORD_W'(r);
            end
        end
    end

    assign scan_hit  = r_pend && (rd_kind == K_FREE) && (rd_ord >= r_req)
                       && (rd_ord < r_best_ord);
    assign split_ord = r_best_ord - ORD_W'(1);
    assign split_bud = r_best + (CW'(1) << split_ord);

    assign pg_oob    = r_pg >= NUM_C;
    assign off_diff  = r_pg - CW'(r_base);
    assign bud_size  = CW'(1) << r_ord;
    assign bud_calc  = off_diff[r_ord] ? (r_pg - bud_size) : (r_pg + bud_size);
    assign bud_bad   = off_diff[r_ord] ? (r_pg < bud_size) : ((r_pg + bud_size) >= NUM_C);
    assign merge_ok  = (rd_kind == K_FREE) && (rd_ord == r_ord);
    assign m_low     = (r_bud < r_pg) ? r_bud : r_pg;
    assign m_high    = (r_bud < r_pg) ? r_pg : r_bud;

    assign i_req.ready = (r_state == S_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_IX) begin
                    n_state = r_clr_init ? S_CARVE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    unique case (t_cmd'(i_req.command))
                        CMD_INIT:  n_state = S_CLEAR;
                        CMD_ALLOC: n_state = S_AREQ;
                        CMD_FREE:  n_state = S_FREAD;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_CARVE:     if (r_ord == '0) n_state = S_RESP;
            S_AREQ:      n_state = areq_found ? S_SCAN : S_RESP;
            S_SCAN:      if (r_idx == LAST_IX) n_state = S_SCAN_LAST;
            S_SCAN_LAST: n_state = S_SPLIT;
            S_SPLIT: begin
                if (r_best_ord > MAX_O || r_best_ord <= r_req) begin
                    n_state = S_RESP;
                end
            end
            S_FREAD:     n_state = pg_oob ? S_RESP : S_FCHK;
            S_FCHK:      n_state = (rd_kind == K_USED) ? S_BUD : S_RESP;
            S_BUD:       n_state = (r_ord >= MAX_O || bud_bad) ? S_RESP : S_BCHK;
            S_BCHK:      n_state = merge_ok ? S_MLOW : S_RESP;
            S_MLOW:      n_state = S_BUD;
            S_RESP:      if (resp_load) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath, table port and response register.
    always_comb begin
        n_clr_init  = r_clr_init;
        n_idx       = r_idx;
        n_bytes     = r_bytes;
        n_pg        = r_pg;
        n_base      = r_base;
        n_pages     = r_pages;
        n_off       = r_off;
        n_ord       = r_ord;
        n_req       = r_req;
        n_best      = r_best;
        n_best_ord  = r_best_ord;
        n_bud       = r_bud;
        n_pend      = 1'b0;
        n_pend_pg   = r_pend_pg;
        n_res_st    = r_res_st;
        n_res_pg    = r_res_pg;
        n_res_ord   = r_res_ord;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_st    = r_out_st;
        n_out_pg    = r_out_pg;
        n_out_ord   = r_out_ord;
        tbl_we      = 1'b0;
        tbl_waddr   = '0;
        tbl_wdata   = '0;
        tbl_raddr   = '0;

        unique case (r_state)
            S_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_idx;
                n_idx     = r_idx + PW'(1);
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_res_st  = ST_OK;
                    n_res_pg  = '0;
                    n_res_ord = '0;
                    unique case (t_cmd'(i_req.command))
                        CMD_INIT: begin
                            n_base     = r_cfg_first;
                            n_pages    = r_cfg_pages;
                            n_idx      = '0;
                            n_clr_init = 1'b1;
                            n_ord      = MAX_O;
                            n_off      = '0;
                        end
                        CMD_ALLOC: n_bytes = i_req.request_bytes;
                        CMD_FREE:  n_pg    = CW'(i_req.page_number);
                        default:   n_res_st = ST_OK;
                    endcase
                end
            end
            S_CARVE: begin
                if (carve_bit) begin
                    if (carve_fits) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = carve_start[PW-1:0];
                        tbl_wdata = {K_FREE, r_ord};
                    end
                    n_off = r_off + carve_size;
                end
                n_ord = r_ord - ORD_W'(1);
            end
            S_AREQ: begin
                n_req      = areq_ord;
                n_idx      = '0;
                n_best     = '0;
                n_best_ord = NO_O;
                if (!areq_found) begin
                    n_res_st = ST_OOM;
                end
            end
            S_SCAN, S_SCAN_LAST: begin
                if (scan_hit) begin
                    n_best     = CW'(r_pend_pg);
                    n_best_ord = rd_ord;
                end
                if (r_state == S_SCAN) begin
                    tbl_raddr = r_idx;
                    n_pend    = 1'b1;
                    n_pend_pg = r_idx;
                    n_idx     = r_idx + PW'(1);
                end
            end
            S_SPLIT: begin
                if (r_best_ord > MAX_O) begin
                    n_res_st = ST_OOM;
                end else if (r_best_ord > r_req) begin
                    if (split_bud < NUM_C) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = split_bud[PW-1:0];
                        tbl_wdata = {K_FREE, split_ord};
                    end
                    n_best_ord = split_ord;
                end else begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_best[PW-1:0];
                    tbl_wdata = {K_USED, r_req};
                    n_res_pg  = r_best;
                    n_res_ord = r_req;
                end
            end
            S_FREAD: begin
                tbl_raddr = r_pg[PW-1:0];
                if (pg_oob) begin
                    n_res_st = ST_BADFREE;
                    n_res_pg = r_pg;
                end
            end
            S_FCHK: begin
                if (rd_kind == K_USED) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_pg[PW-1:0];
                    tbl_wdata = {K_FREE, rd_ord};
                    n_ord     = rd_ord;
                end else begin
                    n_res_st = ST_BADFREE;
                    n_res_pg = r_pg;
                end
            end
            S_BUD: begin
                tbl_raddr = bud_calc[PW-1:0];
                n_bud     = bud_calc;
                n_res_pg  = r_pg;
                n_res_ord = r_ord;
            end
            S_BCHK: begin
                if (merge_ok) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = m_high[PW-1:0];
                    tbl_wdata = '0;
                end
            end
            S_MLOW: begin
                tbl_we    = 1'b1;
                tbl_waddr = m_low[PW-1:0];
                tbl_wdata = {K_FREE, r_ord + ORD_W'(1)};
                n_pg      = m_low;
                n_ord     = r_ord + ORD_W'(1);
            end
            S_RESP: begin
                if (resp_load) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_pg    = r_res_pg[PAGE_F_W-1:0];
                    n_out_ord   = ORDER_F_W'(r_res_ord);
                    n_clr_init  = 1'b0;
                end
            end
            default: n_pend = 1'b0;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_init  <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_init  <= n_clr_init;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bytes    <= n_bytes;
        r_pg       <= n_pg;
        r_base     <= n_base;
        r_pages    <= n_pages;
        r_off      <= n_off;
        r_ord      <= n_ord;
        r_req      <= n_req;
        r_best     <= n_best;
        r_best_ord <= n_best_ord;
        r_bud      <= n_bud;
        r_pend_pg  <= n_pend_pg;
        r_res_st   <= n_res_st;
        r_res_pg   <= n_res_pg;
        r_res_ord  <= n_res_ord;
        r_out_st   <= n_out_st;
        r_out_pg   <= n_out_pg;
        r_out_ord  <= n_out_ord;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_st;
    assign o_rsp.block_page = r_out_pg;
    assign o_rsp.block_log2 = r_out_ord;

    // The table is never written while the block waits for a command.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !tbl_we)
        else $error("page table written while idle");

    // An accepted command closes the request channel in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_req.ready)
        else $error("request taken while a command is in progress");

    // An out-of-memory answer carries no block.
    a_oom_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_st == ST_OOM)) |-> (r_out_pg == '0 && r_out_ord == '0))
        else $error("out-of-memory response carries a block");

    // Merging never climbs past the largest order.
    a_merge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BCHK) |-> (r_ord < MAX_O))
        else $error("merge attempted at the largest order");

endmodule

`default_nettype wire

// ----- dv/buddy_page_allocator_top_test.sv -----
// Self-checking testbench for the buddy page allocator: directed table, then random phases.
// Depends on bpa_pkg, the bpa_req_if/bpa_rsp_if channels and buddy_page_allocator_top.
`default_nettype none

module buddy_page_allocator_top_test
    import bpa_pkg::*;
;

    localparam int NPAGES   = NUM_PAGES_DEF;
    localparam int MAXORD   = ORDER_CAP_DEF;
    localparam int HOLD_LEN = 3000;

    typedef struct packed {
        t_status              st;
        logic [PAGE_F_W-1:0]  pg;
        logic [ORDER_F_W-1:0] ord;
    } t_alloc_result;

    typedef struct {
        t_cmd                cmd;
        logic [BYTES_W-1:0]  bytes;
        logic [PAGE_F_W-1:0] page;
        bit                  typed;
        t_alloc_result       res;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    buddy_page_allocator_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow of the page table and the configuration.
    logic [3:0]          tbl_order [NPAGES];
    t_kind               tbl_kind  [NPAGES];
    int unsigned         shadow_first;
    int unsigned         shadow_pages;
    int unsigned         base_pg;
    int                  live_heads[$];

    t_alloc_result       pending_results[$];
    t_stim_row           directed_rows[$];
    int                  mismatches;
    int                  snd_idle_pct;
    int                  rcv_stall_pct;
    bit                  hold_go;
    bit                  hold_on;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Overall time limit.
    initial begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

    function automatic void clear_table();
        for (int p = 0; p < NPAGES; p++) begin
            tbl_order[p] = '0;
            tbl_kind[p]  = K_NONE;
        end
        live_heads.delete();
    endfunction

    // Works out the response to one command and updates the shadow table.
    function automatic t_alloc_result buddy_predict(t_cmd cmd, logic [BYTES_W-1:0] bytes,
                                                    logic [PAGE_F_W-1:0] page);
        t_alloc_result r;
        logic [BYTES_W:0] npages;
        int unsigned off, start, sz, best, bud, lo, pg;
        int req_ord, best_ord, o;
        r = '{ST_OK, '0, '0};
        case (cmd)
            CMD_INIT: begin
                clear_table();
                base_pg = shadow_first;
                off = 0;
                for (o = MAXORD; o >= 0; o--) begin
                    sz = 32'(1) << o;
                    if (shadow_pages[o]) begin
                        start = base_pg + off;
                        if (start + sz <= NPAGES) begin
                            tbl_kind[start]  = K_FREE;
                            tbl_order[start] = o[3:0];
                        end
                        off += sz;
                    end
                end
            end
            CMD_ALLOC: begin
                npages = ({1'b0, bytes} + 33'(PAGE_ROUND)) >> PAGE_SHIFT;
                req_ord = 0;
                while (req_ord <= MAXORD && (33'd1 << req_ord) < npages) req_ord++;
                best_ord = MAXORD + 1;
                best = 0;
                if (req_ord <= MAXORD) begin
                    for (int p = 0; p < NPAGES; p++) begin
                        if (tbl_kind[p] == K_FREE && int'(tbl_order[p]) >= req_ord &&
                            int'(tbl_order[p]) < best_ord) begin
                            best_ord = int'(tbl_order[p]);
                            best = 32'(p);
                        end
                    end
                end
                if (best_ord > MAXORD) begin
                    r.st = ST_OOM;
                end else begin
                    // Split down, keeping the lower half each time.
                    o = best_ord;
                    while (o > req_ord) begin
                        o--;
                        bud = best + (32'(1) << o);
                        if (bud < NPAGES) begin
                            tbl_kind[bud]  = K_FREE;
                            tbl_order[bud] = o[3:0];
                        end
                    end
                    tbl_kind[best]  = K_USED;
                    tbl_order[best] = req_ord[3:0];
                    live_heads.push_back(int'(best));
                    r.pg  = best[PAGE_F_W-1:0];
                    r.ord = req_ord[3:0];
                end
            end
            CMD_FREE: begin
                pg = 32'(page);
                if (tbl_kind[pg] != K_USED) begin
                    r.st = ST_BADFREE;
                    r.pg = page;
                end else begin
                    foreach (live_heads[i]) if (live_heads[i] == int'(pg)) begin
                        live_heads.delete(i);
                        break;
                    end
                    tbl_kind[pg] = K_FREE;
                    o = int'(tbl_order[pg]);
                    // Merge with the true buddy while it is a free head of equal order.
                    while (o < MAXORD) begin
                        bud = base_pg + ((pg - base_pg) ^ (32'(1) << o));
                        if (bud >= NPAGES || tbl_kind[bud] != K_FREE ||
                            int'(tbl_order[bud]) != o) break;
                        lo = (bud < pg) ? bud : pg;
                        if (bud < pg) begin
                            tbl_kind[pg] = K_NONE;
                            tbl_order[pg] = '0;
                        end else begin
                            tbl_kind[bud] = K_NONE;
                            tbl_order[bud] = '0;
                        end
                        o++;
                        tbl_order[lo] = o[3:0];
                        pg = lo;
                    end
                    r.pg  = pg[PAGE_F_W-1:0];
                    r.ord = o[3:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // APB register write: setup cycle, then access cycle until pready.
    task automatic write_reg(t_reg idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_FIRST_PAGE) shadow_first = value & 32'h3FF;
        else shadow_pages = value & 32'h7FF;
    endtask

    // Offers one command beat, with random idle cycles first, and records the expectation.
    task automatic send_cmd(t_cmd cmd, logic [BYTES_W-1:0] bytes, logic [PAGE_F_W-1:0] page,
                            bit typed, t_alloc_result typed_res);
        t_alloc_result pred;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.command       <= cmd;
        req_ch.request_bytes <= bytes;
        req_ch.page_number   <= page;
        do @(posedge i_clk); while (!req_ch.ready);
        pred = buddy_predict(cmd, bytes, page);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [BYTES_W-1:0] bytes_for_order(int o);
        if (o == 0) return $urandom_range(0, 4096);
        return $urandom_range((32'd1 << (o - 1)) * 4096 + 1, (32'd1 << o) * 4096);
    endfunction

    // Random commands: mostly sized allocations and frees of live blocks, some noise.
    task automatic run_random(int n);
        int sel, o;
        logic [BYTES_W-1:0] rb;
        logic [PAGE_F_W-1:0] rp;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            rb  = $urandom;
            rp  = PAGE_F_W'($urandom);
            if (sel < 45 || (sel < 85 && live_heads.size() == 0)) begin
                o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAXORD) : $urandom_range(0, 3);
                send_cmd(CMD_ALLOC, bytes_for_order(o), rp, 1'b0, '0);
            end else if (sel < 85) begin
                rp = PAGE_F_W'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
                send_cmd(CMD_FREE, rb, rp, 1'b0, '0);
            end else if (sel < 90) begin
                send_cmd(CMD_FREE, rb, rp, 1'b0, '0);
            end else if (sel < 94) begin
                send_cmd(CMD_ALLOC, rb, rp, 1'b0, '0);
            end else if (sel < 97) begin
                send_cmd(CMD_NOP, rb, rp, 1'b0, '0);
            end else begin
                send_cmd(CMD_INIT, rb, rp, 1'b0, '0);
            end
        end
    endtask

    function automatic void add_row(t_cmd cmd, logic [BYTES_W-1:0] bytes,
                                    logic [PAGE_F_W-1:0] page, bit typed,
                                    t_status st, int pg, int ord);
        t_stim_row row;
        row.cmd   = cmd;
        row.bytes = bytes;
        row.page  = page;
        row.typed = typed;
        row.res   = '{st, pg[PAGE_F_W-1:0], ord[ORDER_F_W-1:0]};
        directed_rows.push_back(row);
    endfunction

    // Long receiver hold-off, so the block fills up and stalls its input.
    initial begin
        hold_on = 1'b0;
        @(posedge hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Response side: check each accepted beat, then choose ready for the next cycle.
    initial begin
        t_alloc_result exp_r;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected response beat: status %0d page %0d order %0d",
                                 rsp_ch.status, rsp_ch.block_page, rsp_ch.block_log2);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (rsp_ch.status !== exp_r.st || rsp_ch.block_page !== exp_r.pg ||
                        rsp_ch.block_log2 !== exp_r.ord) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     exp_r.st, exp_r.pg, exp_r.ord, rsp_ch.status,
                                     rsp_ch.block_page, rsp_ch.block_log2);
                    end
                end
            end
            rsp_ch.ready <= !hold_on && ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // Main sequence.
    initial begin
        static int cfg_first [8] = '{0,    1023, 0, 5,    300, 512, 0, 100};
        static int cfg_pages [8] = '{1024, 1024, 0, 1023, 700, 511, 1, 2047};
        mismatches    = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_go       = 1'b0;
        shadow_first  = 0;
        shadow_pages  = POOLSZ_RST;
        base_pg       = 0;
        clear_table();
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_NOP;
        req_ch.request_bytes = '0;
        req_ch.page_number   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table on the reset configuration.
        add_row(CMD_ALLOC, 32'd4096,     10'd0,    1, ST_OOM,     0,    0);
        add_row(CMD_FREE,  32'd0,        10'd0,    1, ST_BADFREE, 0,    0);
        add_row(CMD_NOP,   32'hFFFFFFFF, 10'h3FF,  1, ST_OK,      0,    0);
        add_row(CMD_INIT,  32'd0,        10'd0,    1, ST_OK,      0,    0);
        add_row(CMD_ALLOC, 32'hFFFFFFFF, 10'd0,    1, ST_OOM,     0,    0);
        add_row(CMD_ALLOC, 32'h00400001, 10'd0,    1, ST_OOM,     0,    0);
        add_row(CMD_FREE,  32'd0,        10'h3FF,  1, ST_BADFREE, 1023, 0);
        add_row(CMD_ALLOC, 32'd0,        10'd0,    1, ST_OK,      0,    0);
        add_row(CMD_ALLOC, 32'd4097,     10'd0,    0, ST_OK,      0,    0);
        add_row(CMD_ALLOC, 32'd8193,     10'd0,    0, ST_OK,      0,    0);
        add_row(CMD_ALLOC, 32'd1,        10'd0,    0, ST_OK,      0,    0);
        add_row(CMD_FREE,  32'd0,        10'd2,    0, ST_OK,      0,    0);
        add_row(CMD_FREE,  32'd0,        10'd0,    0, ST_OK,      0,    0);
        add_row(CMD_FREE,  32'd0,        10'd0,    0, ST_OK,      0,    0);
        add_row(CMD_FREE,  32'd0,        10'd1,    0, ST_OK,      0,    0);
        add_row(CMD_FREE,  32'd0,        10'd4,    0, ST_OK,      0,    0);
        add_row(CMD_ALLOC, 32'h00400000, 10'd0,    0, ST_OK,      0,    0);
        add_row(CMD_ALLOC, 32'd4096,     10'd0,    1, ST_OOM,     0,    0);
        add_row(CMD_FREE,  32'd0,        10'd0,    0, ST_OK,      0,    0);
        add_row(CMD_INIT,  32'hFFFFFFFF, 10'h3FF,  1, ST_OK,      0,    0);
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].bytes, directed_rows[i].page,
                     directed_rows[i].typed, directed_rows[i].res);
        wait_drained();

        // Random phases over several pool settings and idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_FIRST_PAGE, cfg_first[ph]);
            write_reg(REG_POOL_PAGES, cfg_pages[ph]);
            snd_idle_pct  = (ph % 4 == 1) ? 70 : (ph % 4 == 3) ? 14 : 0;
            rcv_stall_pct = (ph % 4 == 2) ? 70 : (ph % 4 == 3) ? 14 : 0;
            send_cmd(CMD_INIT, $urandom, PAGE_F_W'($urandom), 1'b1, '{ST_OK, '0, '0});
            if (ph == 4) hold_go = 1'b1;
            run_random(54);
            wait_drained();
        end

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
